[rtl/core/lcd_command_stream_framer_assert.svh]
// Assertion macros for the display command framer.
`ifndef LCD_COMMAND_STREAM_FRAMER_ASSERT_SVH
`define LCD_COMMAND_STREAM_FRAMER_ASSERT_SVH
`ifndef SYNTH
`define LCDCSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdcsf assertion failed");
`define LCDCSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdcsf assertion failed");
`else
`define LCDCSF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LCDCSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/lcdcsf_pkg.sv]
`default_nettype none
package lcdcsf_pkg;

    typedef enum logic [1:0] {
        OP_TABLE  = 2'd0,
        OP_WINDOW = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_ROTATE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_DELAY = 2'd1,
        PH_BYTES = 2'd2
    } t_phase;

    localparam logic [7:0] CMD_COLUMN_SET  = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET    = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;
    localparam logic [7:0] CMD_ACCESS_CTRL = 8'h36;
    localparam logic [7:0] ACCESS_FORCE    = 8'h08;
    localparam logic [10:0] WINDOW_DELAY   = 11'd1;

    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] WIN_LAST_IDX = 4'd10;
    localparam logic [IDX_W-1:0] ROT_LAST_IDX = 4'd1;

    // One request after parsing, held while its results are sent.
    typedef struct packed {
        t_op         op;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_start;
        logic [15:0] y_end;
        logic [15:0] pixel;
        logic        pixel_end;
        logic [7:0]  rotation;
        logic [7:0]  tbl_value;
        logic        tbl_is_data;
        logic [10:0] tbl_delay;
        logic        tbl_done;
    } t_work;

    typedef struct packed {
        logic [15:0] out_value;
        logic        is_data;
        logic        is_word;
        logic [10:0] delay_ms;
        logic        table_done;
        logic        frame_end;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/lcdcsf_gen.sv]
`default_nettype none
module lcdcsf_gen (
    input  var lcdcsf_pkg::t_work         i_work,
    input  wire [lcdcsf_pkg::IDX_W-1:0]   i_idx,
    output lcdcsf_pkg::t_result           o_result
);

    logic [7:0] win_byte;
    logic       win_cmd;

    // Window sequence: column-set with four bytes, page-set with four bytes,
    // then memory-write.
    always_comb begin
        win_byte = 8'h00;
        win_cmd  = 1'b0;
        case (i_idx)
            4'd0: begin
                win_byte = lcdcsf_pkg::CMD_COLUMN_SET;
                win_cmd  = 1'b1;
            end
            4'd1: win_byte = i_work.x_start[15:8];
            4'd2: win_byte = i_work.x_start[7:0];
            4'd3: win_byte = i_work.x_end[15:8];
            4'd4: win_byte = i_work.x_end[7:0];
            4'd5: begin
                win_byte = lcdcsf_pkg::CMD_PAGE_SET;
                win_cmd  = 1'b1;
            end
            4'd6: win_byte = i_work.y_start[15:8];
            4'd7: win_byte = i_work.y_start[7:0];
            4'd8: win_byte = i_work.y_end[15:8];
            4'd9: win_byte = i_work.y_end[7:0];
            4'd10: begin
                win_byte = lcdcsf_pkg::CMD_MEM_WRITE;
                win_cmd  = 1'b1;
            end
            default: begin
                win_byte = 8'h00;
                win_cmd  = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        case (i_work.op)
            lcdcsf_pkg::OP_TABLE: begin
                o_result.out_value  = {8'h00, i_work.tbl_value};
                o_result.is_data    = i_work.tbl_is_data;
                o_result.delay_ms   = i_work.tbl_delay;
                o_result.table_done = i_work.tbl_done;
                o_result.last       = 1'b1;
            end
            lcdcsf_pkg::OP_WINDOW: begin
                o_result.out_value = {8'h00, win_byte};
                o_result.is_data   = ~win_cmd;
                o_result.delay_ms  = (i_idx == 4'd9) ? lcdcsf_pkg::WINDOW_DELAY : 11'd0;
                o_result.last      = (i_idx == lcdcsf_pkg::WIN_LAST_IDX);
            end
            lcdcsf_pkg::OP_PIXEL: begin
                o_result.out_value = i_work.pixel;
                o_result.is_data   = 1'b1;
                o_result.is_word   = 1'b1;
                o_result.frame_end = i_work.pixel_end;
                o_result.last      = 1'b1;
            end
            lcdcsf_pkg::OP_ROTATE: begin
                if (i_idx == 4'd0) begin
                    o_result.out_value = {8'h00, lcdcsf_pkg::CMD_ACCESS_CTRL};
                end else begin
                    o_result.out_value = {8'h00, i_work.rotation | lcdcsf_pkg::ACCESS_FORCE};
                    o_result.is_data   = 1'b1;
                end
                o_result.last = (i_idx == lcdcsf_pkg::ROT_LAST_IDX);
            end
            default: o_result = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/lcd_command_stream_framer.sv]
`default_nettype none
// Display command framer. Requests arrive on the input channel (valid/ready)
// and leave as a stream of results on the output channel (valid/ready), one
// result per transfer, each flagged as command, data byte or pixel word.
// A table byte gives zero or one result, a pixel one, a rotation request two
// and a window request eleven; the final result of a request carries last.
// Each result passes the work register and then the output register.
// A result sequencer steps one result per cycle from a work register into
// the output register while the receiver does not stall, so pixels and
// table bytes sustain one per cycle. Table bytes that give no result
// leave the work register empty.
// The next request is taken while the final result of the current one moves
// into the output register. When the receiver stalls, the output register
// holds and input ready drops once the work register is still occupied.
// Reset drops both valids and returns the table parser to expecting a count
// byte, with the first-of-command flag set.
module lcd_command_stream_framer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_operation,
    input  wire  [7:0]  i_table_byte,
    input  wire  [15:0] i_x_start,
    input  wire  [15:0] i_y_start,
    input  wire  [15:0] i_win_width,
    input  wire  [15:0] i_win_height,
    input  wire  [15:0] i_pixel,
    input  wire         i_pixel_end,
    input  wire  [7:0]  i_rotation,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [15:0] o_out_value,
    output logic        o_is_data,
    output logic        o_is_word,
    output logic [10:0] o_delay_ms,
    output logic        o_table_done,
    output logic        o_frame_end,
    output logic        o_last
);

    `include "lcd_command_stream_framer_assert.svh"

    lcdcsf_pkg::t_phase  r_phase, n_phase;
    logic [7:0]          r_bytes_left, n_bytes_left;
    logic [7:0]          r_pend_delay, n_pend_delay;
    logic                r_first, n_first;

    logic                r_wv;
    lcdcsf_pkg::t_work   r_work, n_work;
    logic [lcdcsf_pkg::IDX_W-1:0] r_idx;
    logic                n_has_result;

    logic                r_ov;
    lcdcsf_pkg::t_result r_out;
    lcdcsf_pkg::t_result gen_result;

    logic                out_free;
    logic                in_xfer;
    logic [7:0]          bytes_dec;

    assign out_free   = ~r_ov | i_out_ready;
    assign o_in_ready = ~r_wv | (out_free & gen_result.last);
    assign in_xfer    = i_in_valid & o_in_ready;
    assign bytes_dec  = r_bytes_left - 8'd1;

    lcdcsf_gen u_gen (
        .i_work   (r_work),
        .i_idx    (r_idx),
        .o_result (gen_result)
    );

    // Table parser and request capture.
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_pend_delay = r_pend_delay;
        n_first      = r_first;
        n_has_result = 1'b1;

        n_work             = '0;
        n_work.op          = lcdcsf_pkg::t_op'(i_operation);
        n_work.x_start     = i_x_start;
        n_work.x_end       = i_x_start + i_win_width - 16'd1;
        n_work.y_start     = i_y_start;
        n_work.y_end       = i_y_start + i_win_height - 16'd1;
        n_work.pixel       = i_pixel;
        n_work.pixel_end   = i_pixel_end;
        n_work.rotation    = i_rotation;
        n_work.tbl_value   = i_table_byte;

        if (n_work.op == lcdcsf_pkg::OP_TABLE) begin
            case (r_phase)
                lcdcsf_pkg::PH_DELAY: begin
                    n_pend_delay = i_table_byte;
                    n_phase      = lcdcsf_pkg::PH_BYTES;
                    n_first      = 1'b1;
                    n_has_result = 1'b0;
                end
                lcdcsf_pkg::PH_BYTES: begin
                    n_work.tbl_is_data = ~r_first;
                    n_first            = 1'b0;
                    n_bytes_left       = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        // Delay byte times five, as 4d + d.
                        n_work.tbl_delay = {1'b0, r_pend_delay, 2'b00}
                                         + {3'b000, r_pend_delay};
                        n_phase          = lcdcsf_pkg::PH_COUNT;
                        n_first          = 1'b1;
                    end
                end
                default: begin
                    n_phase = lcdcsf_pkg::PH_COUNT;
                    if (i_table_byte == 8'd0) begin
                        n_first          = 1'b1;
                        n_work.tbl_value = 8'h00;
                        n_work.tbl_done  = 1'b1;
                    end else begin
                        n_bytes_left = i_table_byte;
                        n_phase      = lcdcsf_pkg::PH_DELAY;
                        n_has_result = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lcdcsf_pkg::PH_COUNT;
            r_bytes_left <= 8'd0;
            r_pend_delay <= 8'd0;
            r_first      <= 1'b1;
        end else if (in_xfer) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_pend_delay <= n_pend_delay;
            r_first      <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv  <= 1'b0;
            r_idx <= '0;
        end else if (in_xfer) begin
            r_wv  <= n_has_result;
            r_idx <= '0;
        end else if (r_wv && out_free) begin
            if (gen_result.last) begin
                r_wv <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_work <= n_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_wv) begin
            r_out <= gen_result;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_value  = r_out.out_value;
    assign o_is_data    = r_out.is_data;
    assign o_is_word    = r_out.is_word;
    assign o_delay_ms   = r_out.delay_ms;
    assign o_table_done = r_out.table_done;
    assign o_frame_end  = r_out.frame_end;
    assign o_last       = r_out.last;

    `LCDCSF_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, r_wv, r_idx <= lcdcsf_pkg::WIN_LAST_IDX)
    `LCDCSF_ASSERT_IMPL(a_word_is_single, i_clk, i_rst_n, o_out_valid && o_is_word, o_is_data && o_last)
    `LCDCSF_ASSERT_IMPL(a_done_clean, i_clk, i_rst_n, o_out_valid && o_table_done, o_last && (o_out_value == 16'd0) && !o_is_data)
    `LCDCSF_ASSERT_NEXT(a_stall_keeps_work, i_clk, i_rst_n, r_wv && !out_free, r_wv && $stable(r_idx))

endmodule
`default_nettype wire
